### hw/rtl/line_pixel_generator_defines.svh
// Assertion macros shared by the line pixel generator RTL.
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define LPG_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("lpg assertion failed");

// Next-cycle implication, checked out of reset.
`define LPG_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("lpg assertion failed");

`else

`define LPG_ASSERT_SAME(label, clk, rst, cond, expr)
`define LPG_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

### hw/rtl/lpg_pkg.sv
// Types and constants of the line pixel generator.
package lpg_pkg;

   localparam int COORD_WIDTH = 10;
   localparam int COLOR_WIDTH = 16;
   // error term: sign, doubled range and one guard bit over the coordinate
   localparam int ERR_WIDTH   = COORD_WIDTH + 3;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   typedef logic [COORD_WIDTH-1:0]      coord_type;
   typedef logic [COLOR_WIDTH-1:0]      color_type;
   typedef logic signed [ERR_WIDTH-1:0] err_type;

   typedef struct packed {
      logic      func;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      color_type color;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      color_type pixel_color;
      logic      last;
   } rsp_type;

   // classified and pre-computed command, front to back
   typedef struct packed {
      logic      is_start;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      logic      step_x_neg;
      logic      step_y_neg;
      logic      x_major;
      err_type   err_init;
      err_type   diag_inc;
      err_type   axis_inc;
      color_type color;
   } cmd_type;

endpackage

### hw/rtl/lpg_front.sv
// Front end: classifies a beat and works out the line setup for start beats.
module lpg_front (
   input  lpg_pkg::req_type req_item,
   output lpg_pkg::cmd_type cmd_item
);

   localparam int PAD = lpg_pkg::ERR_WIDTH - lpg_pkg::COORD_WIDTH;

   logic              x_lt;
   logic              y_lt;
   lpg_pkg::coord_type dx;
   lpg_pkg::coord_type dy;
   logic              x_major;
   lpg_pkg::err_type  major_e;
   lpg_pkg::err_type  minor_e;
   lpg_pkg::err_type  diff;
   lpg_pkg::err_type  axis_inc;

   always_comb begin
      x_lt     = req_item.x_start < req_item.x_end;
      y_lt     = req_item.y_start < req_item.y_end;
      dx       = x_lt ? (req_item.x_end - req_item.x_start)
                      : (req_item.x_start - req_item.x_end);
      dy       = y_lt ? (req_item.y_end - req_item.y_start)
                      : (req_item.y_start - req_item.y_end);
      x_major  = dx > dy;   // ties go to y
      major_e  = x_major ? lpg_pkg::err_type'({{PAD{1'b0}}, dx})
                         : lpg_pkg::err_type'({{PAD{1'b0}}, dy});
      minor_e  = x_major ? lpg_pkg::err_type'({{PAD{1'b0}}, dy})
                         : lpg_pkg::err_type'({{PAD{1'b0}}, dx});
      diff     = minor_e - major_e;
      axis_inc = {minor_e[lpg_pkg::ERR_WIDTH-2:0], 1'b0};

      cmd_item.is_start   = (req_item.func == lpg_pkg::FUNC_START);
      cmd_item.x_start    = req_item.x_start;
      cmd_item.y_start    = req_item.y_start;
      cmd_item.x_end      = req_item.x_end;
      cmd_item.y_end      = req_item.y_end;
      cmd_item.step_x_neg = !x_lt;
      cmd_item.step_y_neg = !y_lt;
      cmd_item.x_major    = x_major;
      cmd_item.diag_inc   = {diff[lpg_pkg::ERR_WIDTH-2:0], 1'b0};
      cmd_item.axis_inc   = axis_inc;
      cmd_item.err_init   = axis_inc - major_e;
      cmd_item.color      = req_item.color;
   end

endmodule

### hw/rtl/lpg_fifo.sv
// Small register FIFO used between front and back and on the result side.
`include "line_pixel_generator_defines.svh"

module lpg_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `LPG_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

endmodule

### hw/rtl/lpg_back.sv
// Back end: holds the line state, steps the rasterizer and emits pixels.
`include "line_pixel_generator_defines.svh"

module lpg_back (
   input  logic             clock,
   input  logic             reset,
   input  lpg_pkg::cmd_type cmd_item,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output lpg_pkg::rsp_type rsp_item
);

   logic               active_ff,  active_in;
   lpg_pkg::coord_type cur_x_ff,   cur_x_in;
   lpg_pkg::coord_type cur_y_ff,   cur_y_in;
   lpg_pkg::coord_type tgt_x_ff,   tgt_x_in;
   lpg_pkg::coord_type tgt_y_ff,   tgt_y_in;
   logic               neg_x_ff,   neg_x_in;
   logic               neg_y_ff,   neg_y_in;
   logic               x_major_ff, x_major_in;
   lpg_pkg::err_type   err_ff,     err_in;
   lpg_pkg::err_type   diag_ff,    diag_in;
   lpg_pkg::err_type   axis_ff,    axis_in;
   lpg_pkg::color_type color_ff,   color_in;

   logic               diag_step;
   lpg_pkg::coord_type next_x;
   lpg_pkg::coord_type next_y;

   assign cmd_pop = !cmd_empty && !rsp_full;

   always_comb begin
      active_in  = active_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      tgt_x_in   = tgt_x_ff;
      tgt_y_in   = tgt_y_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      x_major_in = x_major_ff;
      err_in     = err_ff;
      diag_in    = diag_ff;
      axis_in    = axis_ff;
      color_in   = color_ff;
      rsp_push   = 1'b0;

      // one Bresenham step from the held state
      diag_step = !err_ff[lpg_pkg::ERR_WIDTH-1];
      next_x    = cur_x_ff;
      next_y    = cur_y_ff;
      if (diag_step || x_major_ff) begin
         next_x = neg_x_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      end
      if (diag_step || !x_major_ff) begin
         next_y = neg_y_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
      end

      if (cmd_pop) begin
         if (cmd_item.is_start) begin
            cur_x_in   = cmd_item.x_start;
            cur_y_in   = cmd_item.y_start;
            tgt_x_in   = cmd_item.x_end;
            tgt_y_in   = cmd_item.y_end;
            neg_x_in   = cmd_item.step_x_neg;
            neg_y_in   = cmd_item.step_y_neg;
            x_major_in = cmd_item.x_major;
            err_in     = cmd_item.err_init;
            diag_in    = cmd_item.diag_inc;
            axis_in    = cmd_item.axis_inc;
            color_in   = cmd_item.color;
            rsp_push   = 1'b1;
         end else if (active_ff) begin
            cur_x_in = next_x;
            cur_y_in = next_y;
            err_in   = err_ff + (diag_step ? diag_ff : axis_ff);
            rsp_push = 1'b1;
         end
      end

      rsp_item.pixel_x     = cur_x_in;
      rsp_item.pixel_y     = cur_y_in;
      rsp_item.pixel_color = color_in;
      rsp_item.last        = x_major_in ? (cur_x_in == tgt_x_in) : (cur_y_in == tgt_y_in);
      if (rsp_push) begin
         active_in = !rsp_item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      tgt_x_ff   <= tgt_x_in;
      tgt_y_ff   <= tgt_y_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      x_major_ff <= x_major_in;
      err_ff     <= err_in;
      diag_ff    <= diag_in;
      axis_ff    <= axis_in;
      color_ff   <= color_in;
   end

   `LPG_ASSERT_SAME(a_idle_step_silent, clock, reset, cmd_pop && !cmd_item.is_start && !active_ff, !rsp_push)
   `LPG_ASSERT_NEXT(a_last_ends_line, clock, reset, rsp_push && rsp_item.last, !active_ff)
   `LPG_ASSERT_NEXT(a_mid_keeps_line, clock, reset, rsp_push && !rsp_item.last, active_ff)

endmodule

### hw/rtl/line_pixel_generator.sv
// Top level of the line pixel generator: front end, command queue, back end, result queue.
// Throughput: one beat per cycle each way, start or step alike, while no queue is full.
// A beat is registered in the command queue, then its pixel in the result queue.
// Both queues are 4 deep; the back end steps one pixel per cycle while rsp_full is low.
// Reset (synchronous, active high) empties both queues and leaves no line active.
// Step beats that arrive with no line active are consumed and produce no result.
module line_pixel_generator (
   input  logic             clock,
   input  logic             reset,
   // input channel, queue style
   input  logic             req_push,
   input  lpg_pkg::req_type req_item,
   output logic             req_full,
   // result channel, queue style
   input  logic             rsp_pop,
   output lpg_pkg::rsp_type rsp_item,
   output logic             rsp_empty
);

   // queue depths: enough slack that both sides may stall independently
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   lpg_pkg::cmd_type front_cmd;   // classified beat with setup worked out
   lpg_pkg::cmd_type back_cmd;    // oldest queued command
   logic             cmd_empty;
   logic             cmd_pop;
   logic             rsp_full;
   logic             rsp_push;
   lpg_pkg::rsp_type back_rsp;

   // Front end: decides start vs step; for a start it computes the deltas,
   // step directions, major axis and the error increments.
   lpg_front u_front (
      .req_item (req_item),
      .cmd_item (front_cmd)
   );

   // Command queue: decouples the setup math from the stepping back end.
   lpg_fifo #(
      .item_type (lpg_pkg::cmd_type),
      .DEPTH     (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_item  (back_cmd),
      .empty     (cmd_empty)
   );

   // Back end: one command per cycle whenever the result queue has room.
   lpg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_item  (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (back_rsp)
   );

   // Result queue: holds finished pixels while the consumer stalls.
   lpg_fifo #(
      .item_type (lpg_pkg::rsp_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_item),
      .empty     (rsp_empty)
   );

endmodule
